@@ sv/bsf_pkg.sv @@
// Package for the byte stream FIFO: opcodes, error codes, controller states
// and the command/status structs between controller and datapath. No dependencies.
`default_nettype none
package bsf_pkg;

	localparam int FIFO_BYTES_DEF = 256;

	typedef logic [2:0] bsf_op_t;
	localparam bsf_op_t OP_STREAM_READ  = 3'd0;
	localparam bsf_op_t OP_STREAM_WRITE = 3'd1;
	localparam bsf_op_t OP_STATUS_READ  = 3'd2;
	localparam bsf_op_t OP_STATUS_WRITE = 3'd3;
	localparam bsf_op_t OP_PROBE        = 3'd4;

	typedef logic [1:0] bsf_err_t;
	localparam bsf_err_t ERR_NONE     = 2'd0;
	localparam bsf_err_t ERR_UNDERRUN = 2'd1;
	localparam bsf_err_t ERR_OVERRUN  = 2'd2;

	localparam logic [1:0] SIZE_1B = 2'd0;
	localparam logic [1:0] SIZE_2B = 2'd1;
	localparam logic [1:0] SIZE_4B = 2'd2;
	localparam logic [1:0] SIZE_8B = 2'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_WR,
		ST_RD,
		ST_RD_WAIT,
		ST_FIN
	} bsf_state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;      // latch an accepted request
		logic exec;      // evaluate fit of the latched request
		logic wr_step;   // push one byte
		logic rd_step;   // pop one byte (issue RAM read)
		logic out_load;  // load result register, commit occupancy
	} bsf_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic go_rd;     // stream read that fits
		logic go_wr;     // stream write that fits
		logic last_byte; // byte step counter on final byte
		logic out_free;  // result register can take a new result
	} bsf_sts_t;

	// highest byte index of an access
	function automatic logic [2:0] last_idx(input logic [1:0] size);
		logic [2:0] r;
		unique case (size)
			SIZE_1B: r = 3'd0;
			SIZE_2B: r = 3'd1;
			SIZE_4B: r = 3'd3;
			SIZE_8B: r = 3'd7;
			default: r = 3'd0;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

@@ sv/bsf_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module bsf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

@@ sv/bsf_ctrl.sv @@
// Controller state machine for the byte stream FIFO.
// Depends on bsf_pkg.
`default_nettype none
module bsf_ctrl
	import bsf_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     s_tvalid,
	output logic          s_tready,
	input  wire bsf_sts_t sts,
	output bsf_cmd_t      cmd
);

	bsf_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		cmd      = '0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				if (sts.go_rd) begin
					state_d = ST_RD;
				end else if (sts.go_wr) begin
					state_d = ST_WR;
				end else begin
					state_d = ST_FIN;
				end
			end
			ST_WR: begin
				cmd.wr_step = 1'b1;
				if (sts.last_byte) begin
					state_d = ST_FIN;
				end
			end
			ST_RD: begin
				cmd.rd_step = 1'b1;
				if (sts.last_byte) begin
					state_d = ST_RD_WAIT;
				end
			end
			ST_RD_WAIT: begin
				state_d = ST_FIN;
			end
			ST_FIN: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					s_tready     = 1'b1;
					if (s_tvalid) begin
						cmd.load = 1'b1;
						state_d  = ST_EXEC;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

@@ sv/bsf_dp.sv @@
// Datapath of the byte stream FIFO: request latch, pointers, occupancy,
// byte store, read assembly and result register. Depends on bsf_pkg, bsf_ram.
`default_nettype none
module bsf_dp
	import bsf_pkg::*;
#(
	parameter int FIFO_BYTES = FIFO_BYTES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic [63:0] s_tdata,
	input  wire logic [5:0]  s_tuser,
	output logic      [63:0] m_tdata,
	output logic      [2:0]  m_tuser,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	input  wire bsf_cmd_t    cmd,
	output bsf_sts_t         sts
);

	localparam int IW = $clog2(FIFO_BYTES);
	localparam int CW = $clog2(FIFO_BYTES + 1);

	bsf_op_t     op_q;
	logic [1:0]  size_q;
	logic        probe_q;
	logic [63:0] wdata_q;
	logic        fit_q;
	logic [IW-1:0] head_q, tail_q;
	logic [CW-1:0] count_q;
	logic [2:0]  k_q;
	logic        cap_vld_s1;
	logic [2:0]  cap_idx_s1;
	logic [63:0] rdata_q;
	logic        m_tvalid_q;
	logic [7:0]  ram_rdata;

	logic [3:0]  len;
	logic        rfit, wfit, fit_now;
	logic [63:0] res_data;
	bsf_err_t    res_err;
	logic        res_ok;
	logic [63:0] count_ext;

	assign len     = 4'd1 << size_q;
	assign rfit    = count_q >= CW'(len);
	assign wfit    = ({1'b0, count_q} + (CW + 1)'(len)) <= (CW + 1)'(FIFO_BYTES);

	always_comb begin
		unique case (op_q)
			OP_STREAM_READ:  fit_now = rfit;
			OP_STREAM_WRITE: fit_now = wfit;
			OP_PROBE:        fit_now = probe_q ? rfit : wfit;
			default:         fit_now = 1'b0;
		endcase
	end

	assign sts.go_rd     = (op_q == OP_STREAM_READ) && rfit;
	assign sts.go_wr     = (op_q == OP_STREAM_WRITE) && wfit;
	assign sts.last_byte = k_q == last_idx(size_q);
	assign sts.out_free  = !m_tvalid_q || m_tready;

	// request latch
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= s_tuser[2:0];
			size_q  <= s_tuser[4:3];
			probe_q <= s_tuser[5];
			wdata_q <= s_tdata;
		end
		if (cmd.exec) begin
			fit_q <= fit_now;
		end
	end

	// pointers, occupancy, byte step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q     <= '0;
			tail_q     <= '0;
			count_q    <= '0;
			k_q        <= '0;
			cap_vld_s1 <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			cap_vld_s1 <= cmd.rd_step;
			if (cmd.load) begin
				k_q <= '0;
			end else if (cmd.wr_step || cmd.rd_step) begin
				k_q <= k_q + 3'd1;
			end
			if (cmd.wr_step) begin
				tail_q <= (tail_q == IW'(FIFO_BYTES - 1)) ? '0 : tail_q + IW'(1);
			end
			if (cmd.rd_step) begin
				head_q <= (head_q == IW'(FIFO_BYTES - 1)) ? '0 : head_q + IW'(1);
			end
			if (cmd.out_load && fit_q) begin
				if (op_q == OP_STREAM_READ) begin
					count_q <= count_q - CW'(len);
				end else if (op_q == OP_STREAM_WRITE) begin
					count_q <= count_q + CW'(len);
				end
			end
			if (cmd.out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	bsf_ram #(
		.WIDTH(8),
		.DEPTH(FIFO_BYTES)
	) u_ram (
		.clk  (clk),
		.we   (cmd.wr_step),
		.waddr(tail_q),
		.wdata(wdata_q[8*k_q +: 8]),
		.re   (cmd.rd_step),
		.raddr(head_q),
		.rdata(ram_rdata)
	);

	// read assembly: RAM data lands in the cycle after the address is issued
	always_ff @(posedge clk) begin
		cap_idx_s1 <= k_q;
		if (cmd.load) begin
			rdata_q <= '0;
		end else if (cap_vld_s1) begin
			rdata_q[8*cap_idx_s1 +: 8] <= ram_rdata;
		end
	end

	assign count_ext = 64'(count_q);

	always_comb begin
		res_data = '0;
		res_err  = ERR_NONE;
		res_ok   = 1'b0;
		unique case (op_q)
			OP_STREAM_READ: begin
				if (fit_q) begin
					res_data = rdata_q;
				end else begin
					res_err = ERR_UNDERRUN;
				end
			end
			OP_STREAM_WRITE: begin
				if (!fit_q) begin
					res_err = ERR_OVERRUN;
				end
			end
			OP_STATUS_READ: begin
				unique case (size_q)
					SIZE_1B: res_data = {56'd0, count_ext[7:0]};
					SIZE_2B: res_data = {48'd0, count_ext[15:0]};
					SIZE_4B: res_data = {32'd0, count_ext[31:0]};
					default: res_data = count_ext;
				endcase
			end
			OP_PROBE: begin
				res_ok = fit_q;
			end
			default: begin
				res_data = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			m_tdata <= res_data;
			m_tuser <= {res_ok, res_err};
		end
	end

	assign m_tvalid = m_tvalid_q;

endmodule
`default_nettype wire

@@ sv/byte_stream_fifo_top.sv @@
// Byte stream FIFO top level. Each request is latched and checked for fit;
// status, probe and failed accesses then give their result, while a stream
// write or read first moves its bytes one byte per cycle through the byte-wide
// store. The next request is taken only once the result register loads.
// Reset (arst_n low, asynchronous) empties the FIFO and drops any pending result.
// Depends on bsf_pkg, bsf_ctrl, bsf_dp.
`default_nettype none
module byte_stream_fifo_top
	import bsf_pkg::*;
#(
	parameter int FIFO_BYTES = FIFO_BYTES_DEF  // byte capacity, 8..65536
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// request channel
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [63:0] s_tdata,   // [63:0] write_data
	input  wire logic [5:0]  s_tuser,   // [2:0] opcode, [4:3] size_log2, [5] probe_is_read
	// result channel
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [63:0] m_tdata,   // [63:0] read_data
	output logic      [2:0]  m_tuser    // [1:0] error_code, [2] would_succeed
);

	bsf_cmd_t cmd;
	bsf_sts_t sts;

	// Controller sequences each request: latch, fit check, one byte per
	// cycle against the store, then result hand-off. The next request is
	// taken in the same cycle the result register loads.
	bsf_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.sts     (sts),
		.cmd     (cmd)
	);

	// Datapath: pointers wrap at FIFO_BYTES, occupancy commits only when
	// the result of a successful stream access is loaded.
	bsf_dp #(
		.FIFO_BYTES(FIFO_BYTES)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.cmd     (cmd),
		.sts     (sts)
	);

`ifndef SYNTHESIS
	// a result never overwrites one still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!m_tvalid || m_tready))
		else $error("result register overwritten");

	// no request taken while bytes move
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.wr_step || cmd.rd_step) |-> !s_tready)
		else $error("request accepted during byte transfer");

	// push and pop never share a cycle
	a_step_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.wr_step && cmd.rd_step))
		else $error("push and pop in same cycle");

	// error code is one of the defined codes
	a_err_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser[1:0] == ERR_NONE || m_tuser[1:0] == ERR_UNDERRUN
			|| m_tuser[1:0] == ERR_OVERRUN))
		else $error("undefined error code");
`endif

endmodule
`default_nettype wire

@@ tb/sv/byte_stream_fifo_top_tb.sv @@
// Self-checking testbench for byte_stream_fifo_top: directed table, then biased random traffic.
// Every accepted request runs through a local byte FIFO predictor, checked on the result stream.
// Depends on bsf_pkg and byte_stream_fifo_top.
`default_nettype none
module byte_stream_fifo_top_tb
	import bsf_pkg::*;
();

	localparam int DEPTH = FIFO_BYTES_DEF;
	// opcodes the block must ignore
	localparam bsf_op_t OP_UNUSED_LO = 3'd5;
	localparam bsf_op_t OP_UNUSED_HI = 3'd7;
	localparam int RANDOM_USEFUL = 1630;

	typedef struct {
		logic [63:0] rdata;
		bsf_err_t    err;
		logic        ok;
	} access_result_t;

	typedef struct {
		bsf_op_t        op;
		logic [1:0]     size;
		logic           probe;
		logic [63:0]    data;
		int             reps;
		logic           fixed;  // use the typed outcome instead of the predictor
		access_result_t want;
	} req_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata = '0;
	logic [5:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [63:0] m_tdata;
	logic [2:0]  m_tuser;

	// typed outcome travels alongside the request
	logic           req_fixed = 1'b0;
	access_result_t req_want;

	// predictor state
	logic [7:0] fifo_mem [DEPTH];
	int         rd_ptr = 0;
	int         wr_ptr = 0;
	int         held = 0;

	access_result_t pending_results [$];
	req_row_t       directed_rows [$];
	int             n_bad = 0;
	bit             calm = 1'b0;

	byte_stream_fifo_top uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("Verification failed");
		$finish;
	end

	function automatic access_result_t outcome(logic [63:0] rdata, bsf_err_t err, logic ok);
		access_result_t r;
		r.rdata = rdata;
		r.err = err;
		r.ok = ok;
		return r;
	endfunction

	// one access against the local FIFO image; updates pointers and occupancy
	function automatic access_result_t apply_access(bsf_op_t op, logic [1:0] size, logic probe,
			logic [63:0] wdata);
		access_result_t r;
		int len;
		int k;
		r = outcome(64'd0, ERR_NONE, 1'b0);
		len = 1 << size;
		case (op)
			OP_STREAM_READ: begin
				if (held >= len) begin
					for (k = 0; k < len; k++) begin
						r.rdata[8*k +: 8] = fifo_mem[rd_ptr];
						rd_ptr = (rd_ptr + 1) % DEPTH;
					end
					held -= len;
				end else begin
					r.err = ERR_UNDERRUN;
				end
			end
			OP_STREAM_WRITE: begin
				if (held + len <= DEPTH) begin
					for (k = 0; k < len; k++) begin
						fifo_mem[wr_ptr] = wdata[8*k +: 8];
						wr_ptr = (wr_ptr + 1) % DEPTH;
					end
					held += len;
				end else begin
					r.err = ERR_OVERRUN;
				end
			end
			OP_STATUS_READ: begin
				r.rdata = 64'(held);
				if (len < 8)
					r.rdata &= (64'd1 << (8 * len)) - 64'd1;
			end
			OP_PROBE: begin
				r.ok = probe ? (held >= len) : (held + len <= DEPTH);
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		n_bad++;
		$display("MISMATCH at %0t: %s got %h want %h", $time, what, got, want);
	endtask

	task automatic add_row(bsf_op_t op, logic [1:0] size, logic probe, logic [63:0] data,
			int reps, logic fixed, access_result_t want);
		req_row_t row;
		row.op = op;
		row.size = size;
		row.probe = probe;
		row.data = data;
		row.reps = reps;
		row.fixed = fixed;
		row.want = want;
		directed_rows = {directed_rows, row};
	endtask

	// present one request and hold it until taken; random gap in front unless calm
	task automatic issue(bsf_op_t op, logic [1:0] size, logic probe, logic [63:0] data,
			logic fixed, access_result_t want);
		while (!calm && $urandom_range(0, 99) < 19) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= data;
		s_tuser <= {probe, size, op};
		req_fixed <= fixed;
		req_want <= want;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	// stop sending until the block has delivered everything owed
	task automatic drain_pause();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// result side stalls at random, never during the calm window
	always @(posedge clk) begin
		m_tready <= calm || ($urandom_range(0, 99) >= 19);
	end

	// predict on every accepted request
	always @(posedge clk) begin : predict_blk
		access_result_t r;
		if (arst_n && s_tvalid && s_tready) begin
			r = apply_access(bsf_op_t'(s_tuser[2:0]), s_tuser[4:3], s_tuser[5], s_tdata);
			if (req_fixed)
				r = req_want;
			pending_results = {pending_results, r};
		end
	end

	// compare every accepted result with the oldest expectation
	always @(posedge clk) begin : check_blk
		access_result_t w;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("result with nothing pending", m_tdata, 64'd0);
			end else begin
				w = pending_results.pop_front();
				if (m_tdata !== w.rdata)
					report_mismatch("read_data", m_tdata, w.rdata);
				if (m_tuser[1:0] !== w.err)
					report_mismatch("error_code", 64'(m_tuser[1:0]), 64'(w.err));
				if (m_tuser[2] !== w.ok)
					report_mismatch("would_succeed", 64'(m_tuser[2]), 64'(w.ok));
			end
		end
	end

	initial begin : stimulus
		access_result_t none;
		req_row_t row;
		int j;
		int useful;
		int pick;
		bit filling;
		bsf_op_t op;

		none = outcome(64'd0, ERR_NONE, 1'b0);
		// empty FIFO corner cases
		add_row(OP_STATUS_READ, SIZE_8B, 1'b0, 64'd0, 1, 1'b1, none);
		add_row(OP_STREAM_READ, SIZE_1B, 1'b0, 64'd0, 1, 1'b1, outcome(64'd0, ERR_UNDERRUN, 1'b0));
		add_row(OP_PROBE, SIZE_1B, 1'b1, 64'd0, 1, 1'b1, none);
		add_row(OP_PROBE, SIZE_8B, 1'b0, 64'd0, 1, 1'b1, outcome(64'd0, ERR_NONE, 1'b1));
		add_row(OP_STATUS_WRITE, SIZE_8B, 1'b1, '1, 1, 1'b1, none);
		add_row(OP_UNUSED_LO, SIZE_8B, 1'b1, '1, 1, 1'b1, none);
		add_row(OP_UNUSED_HI, SIZE_2B, 1'b0, '1, 1, 1'b1, none);
		// mixed widths, unused upper bytes set
		add_row(OP_STREAM_WRITE, SIZE_1B, 1'b0, 64'hFFFF_FFFF_FFFF_FF5A, 1, 1'b0, none);
		add_row(OP_STREAM_WRITE, SIZE_2B, 1'b0, 64'hFFFF_FFFF_FFFF_C3A5, 1, 1'b0, none);
		add_row(OP_STREAM_WRITE, SIZE_4B, 1'b0, 64'hFFFF_FFFF_0123_4567, 1, 1'b0, none);
		add_row(OP_STREAM_WRITE, SIZE_8B, 1'b0, '1, 1, 1'b0, none);
		add_row(OP_STATUS_READ, SIZE_1B, 1'b0, 64'd0, 1, 1'b0, none);
		add_row(OP_STREAM_READ, SIZE_8B, 1'b0, 64'd0, 1, 1'b0, none);
		// 7 bytes left, 8 asked
		add_row(OP_STREAM_READ, SIZE_8B, 1'b0, 64'd0, 1, 1'b1, outcome(64'd0, ERR_UNDERRUN, 1'b0));
		add_row(OP_STREAM_READ, SIZE_4B, 1'b0, 64'd0, 1, 1'b0, none);
		add_row(OP_STREAM_READ, SIZE_2B, 1'b0, 64'd0, 1, 1'b0, none);
		add_row(OP_STREAM_READ, SIZE_1B, 1'b0, 64'd0, 1, 1'b0, none);
		// fill to capacity
		add_row(OP_STREAM_WRITE, SIZE_8B, 1'b0, 64'h8040_2010_0804_0201, DEPTH / 8, 1'b0, none);
		// 256 held: truncated to zero in one byte
		add_row(OP_STATUS_READ, SIZE_1B, 1'b0, 64'd0, 1, 1'b1, none);
		add_row(OP_STATUS_READ, SIZE_2B, 1'b0, 64'd0, 1, 1'b1, outcome(64'd256, ERR_NONE, 1'b0));
		add_row(OP_STREAM_WRITE, SIZE_1B, 1'b0, 64'hFF, 1, 1'b1, outcome(64'd0, ERR_OVERRUN, 1'b0));
		add_row(OP_PROBE, SIZE_1B, 1'b0, 64'd0, 1, 1'b1, none);
		add_row(OP_PROBE, SIZE_8B, 1'b1, 64'd0, 1, 1'b1, outcome(64'd0, ERR_NONE, 1'b1));
		add_row(OP_STREAM_READ, SIZE_8B, 1'b0, 64'd0, DEPTH / 8, 1'b0, none);
		add_row(OP_PROBE, SIZE_1B, 1'b1, 64'd0, 1, 1'b1, none);
		add_row(OP_STATUS_READ, SIZE_4B, 1'b0, 64'd0, 1, 1'b1, none);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			row = directed_rows[i];
			for (j = 0; j < row.reps; j++)
				issue(row.op, row.size, row.probe, row.data, row.fixed, row.want);
		end
		drain_pause();

		// random traffic; bias swings occupancy between empty and full
		useful = 0;
		filling = 1'b1;
		while (useful < RANDOM_USEFUL) begin
			calm = (useful >= 700 && useful < 1000);
			if (useful == 350 || useful == 1400)
				drain_pause();
			if (held >= DEPTH - 4 && $urandom_range(0, 9) == 0)
				filling = 1'b0;
			else if (held <= 3 && $urandom_range(0, 9) == 0)
				filling = 1'b1;
			pick = $urandom_range(0, 99);
			if (pick < 50)
				op = ($urandom_range(0, 99) < (filling ? 75 : 25)) ? OP_STREAM_WRITE
				                                                   : OP_STREAM_READ;
			else if (pick < 65)
				op = OP_STATUS_READ;
			else if (pick < 85)
				op = OP_PROBE;
			else if (pick < 90)
				op = OP_STATUS_WRITE;
			else
				op = bsf_op_t'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
			issue(op, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
				{$urandom, $urandom}, 1'b0, none);
			if (op != OP_STATUS_WRITE && op < OP_UNUSED_LO)
				useful++;
		end
		calm = 1'b0;

		drain_pause();
		repeat (20) @(posedge clk);
		if (n_bad == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
`default_nettype wire
